[rtl/mbet_pkg.sv]
package mbet_pkg;

    localparam int FRAC_BITS = 22;
    localparam int REG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [REG_IDX_W-1:0] REG_REAL_ORIGIN     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_REAL_STEP       = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_IMAG_ORIGIN     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_IMAG_STEP       = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ITERATION_LIMIT = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE_BOUND    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_INSIDE_COLOUR   = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OUTSIDE_COLOUR  = 3'd7;

    localparam logic signed [31:0] RST_REAL_ORIGIN     = -32'sd10485760;
    localparam logic [30:0]        RST_REAL_STEP       = 31'd163840;
    localparam logic signed [31:0] RST_IMAG_ORIGIN     = -32'sd10485760;
    localparam logic [30:0]        RST_IMAG_STEP       = 31'd163840;
    localparam logic [7:0]         RST_ITERATION_LIMIT = 8'd100;
    localparam logic [7:0]         RST_ESCAPE_BOUND    = 8'd16;
    localparam logic [31:0]        RST_INSIDE_COLOUR   = 32'hFF64FFFF;
    localparam logic [31:0]        RST_OUTSIDE_COLOUR  = 32'hFFFFFFFF;

    typedef struct packed {
        logic [6:0] column;
        logic [6:0] row;
    } in_item_t;

    typedef struct packed {
        logic [6:0]  out_column;
        logic [6:0]  out_row;
        logic [7:0]  iterations;
        logic        inside_res;
        logic [31:0] pixel_colour;
    } out_item_t;

    // Context of one pixel as it travels around the ring of cells.
    typedef struct packed {
        logic               valid;
        logic               done;
        logic               prod;   // rr, ii and ri hold the products of zr and zi
        logic               first;  // z still equals c, no magnitude check yet
        logic [7:0]         n;
        logic [6:0]         column;
        logic [6:0]         row;
        logic signed [31:0] cr;
        logic signed [31:0] ci;
        logic signed [31:0] zr;
        logic signed [31:0] zi;
        logic signed [63:0] rr;
        logic signed [63:0] ii;
        logic signed [63:0] ri;
    } ctx_t;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v[63:31] == {33{v[63]}})
        begin
            r = v[31:0];
        end
        else if (v[63])
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = 32'sh7FFFFFFF;
        end
        return r;
    endfunction

endpackage

[rtl/mbet_cell.sv]
module mbet_cell
    import mbet_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] limit,
    input  logic [7:0] bound,
    input  ctx_t       ctx_i,
    output ctx_t       ctx_o
);

    ctx_t ctx_reg;
    ctx_t ctx_next;

    logic signed [63:0] rr_m;
    logic signed [63:0] ii_m;
    logic signed [63:0] ri_m;
    logic signed [63:0] diff_w;
    logic signed [63:0] re_w;
    logic signed [63:0] im_w;
    logic [63:0]        mag_w;
    logic [63:0]        bound_w;
    logic               escape_w;
    logic [7:0]         n_inc;

    assign rr_m = ctx_i.zr * ctx_i.zr;
    assign ii_m = ctx_i.zi * ctx_i.zi;
    assign ri_m = ctx_i.zr * ctx_i.zi;

    // Each square is at most 2^62, so the unsigned sum always fits in 64 bits.
    assign mag_w    = ctx_i.rr + ctx_i.ii;
    assign bound_w  = {12'd0, bound, 44'd0};
    assign escape_w = mag_w > bound_w;

    assign diff_w = ctx_i.rr - ctx_i.ii;
    assign re_w   = (diff_w >>> FRAC_BITS) + $signed({{32{ctx_i.cr[31]}}, ctx_i.cr});
    assign im_w   = (ctx_i.ri >>> (FRAC_BITS - 1)) + $signed({{32{ctx_i.ci[31]}}, ctx_i.ci});
    assign n_inc  = ctx_i.n + 8'd1;

    always_comb
    begin
        ctx_next = ctx_i;
        if (ctx_i.valid && !ctx_i.done)
        begin
            if (!ctx_i.prod)
            begin
                ctx_next.rr   = rr_m;
                ctx_next.ii   = ii_m;
                ctx_next.ri   = ri_m;
                ctx_next.prod = 1'b1;
            end
            else
            begin
                ctx_next.prod = 1'b0;
                if (!ctx_i.first && escape_w)
                begin
                    ctx_next.done = 1'b1;
                end
                else if (!ctx_i.first && n_inc == limit)
                begin
                    ctx_next.n    = n_inc;
                    ctx_next.done = 1'b1;
                end
                else
                begin
                    if (!ctx_i.first)
                    begin
                        ctx_next.n = n_inc;
                    end
                    ctx_next.zr    = clamp32(re_w);
                    ctx_next.zi    = clamp32(im_w);
                    ctx_next.first = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctx_reg <= '0;
        end
        else if (en)
        begin
            ctx_reg <= ctx_next;
        end
    end

    assign ctx_o = ctx_reg;

endmodule

[rtl/mandelbrot_escape_time.sv]
// Mandelbrot escape-time engine: one pixel coordinate in, one colored result out.
// Input channel in_valid / in_stall / in_data carries a column and row. The pixel
// is mapped to c = origin + index * step and iterated as z = z*z + c in signed
// Q10.22 until |z|^2 passes the escape bound or the iteration limit is reached.
// Output channel out_valid / out_stall / out_data returns the echoed coordinate,
// the iteration count, the inside flag and the chosen RGBA word.
// A pixel circulates around a ring of two cells: one cell forms the three
// products of z, the next one checks the magnitude and forms the new z. The
// mapped point is registered before it enters the ring. The default iteration
// limit is 100. One pixel is in the block at a time; in_stall is high while
// it is there.
// The result sits in an output register, so the next pixel is accepted while
// the receiver stalls that result. If a second result is ready before the first
// is taken, the ring holds it in place until the output register frees up.
// Reset empties the ring and loads the configuration registers with their
// defaults. The user must make configuration writes (cfg_we, cfg_index,
// cfg_data) only while the block is idle; the block itself does not enforce this.
module mandelbrot_escape_time
    import mbet_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [REG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output out_item_t             out_data
);

    localparam int CELLS = 2;

    logic signed [31:0] real_origin_reg;
    logic [30:0]        real_step_reg;
    logic signed [31:0] imag_origin_reg;
    logic [30:0]        imag_step_reg;
    logic [7:0]         iteration_limit_reg;
    logic [7:0]         escape_bound_reg;
    logic [31:0]        inside_colour_reg;
    logic [31:0]        outside_colour_reg;

    logic               out_valid_reg;
    out_item_t          out_data_reg;

    logic               map_valid_reg;
    ctx_t               map_ctx_reg;

    ctx_t               cell_in  [CELLS];
    ctx_t               cell_out [CELLS];
    ctx_t               load_ctx;
    ctx_t               done_ctx;
    logic               busy;
    logic               accept;
    logic               retire_req;
    logic               out_free;
    logic               retire;
    logic               ring_en;
    logic               inside_w;

    logic [37:0]        re_prod;
    logic [37:0]        im_prod;
    logic signed [63:0] re_map;
    logic signed [63:0] im_map;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            real_origin_reg     <= RST_REAL_ORIGIN;
            real_step_reg       <= RST_REAL_STEP;
            imag_origin_reg     <= RST_IMAG_ORIGIN;
            imag_step_reg       <= RST_IMAG_STEP;
            iteration_limit_reg <= RST_ITERATION_LIMIT;
            escape_bound_reg    <= RST_ESCAPE_BOUND;
            inside_colour_reg   <= RST_INSIDE_COLOUR;
            outside_colour_reg  <= RST_OUTSIDE_COLOUR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REAL_ORIGIN:     real_origin_reg     <= $signed(cfg_data);
                REG_REAL_STEP:       real_step_reg       <= cfg_data[30:0];
                REG_IMAG_ORIGIN:     imag_origin_reg     <= $signed(cfg_data);
                REG_IMAG_STEP:       imag_step_reg       <= cfg_data[30:0];
                REG_ITERATION_LIMIT: iteration_limit_reg <= cfg_data[7:0];
                REG_ESCAPE_BOUND:    escape_bound_reg    <= cfg_data[7:0];
                REG_INSIDE_COLOUR:   inside_colour_reg   <= cfg_data;
                REG_OUTSIDE_COLOUR:  outside_colour_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    // Map the pixel onto the complex plane.
    assign re_prod = in_data.column * real_step_reg;
    assign im_prod = in_data.row * imag_step_reg;
    assign re_map  = $signed({{32{real_origin_reg[31]}}, real_origin_reg})
                   + $signed({26'd0, re_prod});
    assign im_map  = $signed({{32{imag_origin_reg[31]}}, imag_origin_reg})
                   + $signed({26'd0, im_prod});

    always_comb
    begin
        load_ctx        = '0;
        load_ctx.valid  = 1'b1;
        load_ctx.first  = 1'b1;
        load_ctx.column = in_data.column;
        load_ctx.row    = in_data.row;
        load_ctx.cr     = clamp32(re_map);
        load_ctx.ci     = clamp32(im_map);
        load_ctx.zr     = load_ctx.cr;
        load_ctx.zi     = load_ctx.ci;
        // A zero limit means no iteration runs at all.
        load_ctx.done   = (iteration_limit_reg == 8'd0);
    end

    always_comb
    begin
        busy       = map_valid_reg;
        retire_req = 1'b0;
        done_ctx   = cell_out[CELLS-1];
        for (int k = 0; k < CELLS; k++)
        begin
            busy = busy | cell_out[k].valid;
            if (cell_out[k].valid && cell_out[k].done)
            begin
                retire_req = 1'b1;
                done_ctx   = cell_out[k];
            end
        end
    end

    assign accept   = in_valid && !busy;
    assign out_free = !out_valid_reg || !out_stall;
    assign retire   = retire_req && out_free;
    assign ring_en  = !(retire_req && !out_free);
    assign in_stall = busy;

    // The mapped point is registered here so that the mapping and the
    // first squaring fall in different cycles. The ring is empty when it enters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_valid_reg <= 1'b0;
        end
        else
        begin
            map_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            map_ctx_reg <= load_ctx;
        end
    end

    // A finished context is dropped from the ring as it moves on; the ring only
    // moves when that context is written to the output register.
    always_comb
    begin
        for (int k = 0; k < CELLS; k++)
        begin
            cell_in[k] = cell_out[(k + CELLS - 1) % CELLS];
            cell_in[k].valid = cell_out[(k + CELLS - 1) % CELLS].valid
                             && !cell_out[(k + CELLS - 1) % CELLS].done;
        end
        if (map_valid_reg)
        begin
            cell_in[0] = map_ctx_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CELLS; g++)
        begin : g_cell
            mbet_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .en    (ring_en),
                .limit (iteration_limit_reg),
                .bound (escape_bound_reg),
                .ctx_i (cell_in[g]),
                .ctx_o (cell_out[g])
            );
        end
    endgenerate

    assign inside_w = (done_ctx.n == iteration_limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (retire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            out_data_reg.out_column   <= done_ctx.column;
            out_data_reg.out_row      <= done_ctx.row;
            out_data_reg.iterations   <= done_ctx.n;
            out_data_reg.inside_res   <= inside_w;
            out_data_reg.pixel_colour <= inside_w ? inside_colour_reg : outside_colour_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
